/* design/uv_sphere_mesh_generator_macros.svh */
// assertion macros for the uv sphere mesh generator
// expects clk and arst_n in the scope of each use
`ifndef UV_SPHERE_MESH_GENERATOR_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_MACROS_SVH

// condition implies consequence in the same cycle
`define USMG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define USMG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/usmg_pkg.sv */
// shared types, constants and helper functions of the uv sphere mesh generator
// no dependencies; used by usmg_sin_pipe and uv_sphere_mesh_generator
`default_nettype none

package usmg_pkg;

	// output format and count limits
	localparam int COORD_FRAC_BITS = 14;
	localparam int MAX_DIVISIONS = 255;
	localparam int COORD_SHIFT = 30 - COORD_FRAC_BITS;

	// fixed point constants, q30
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [61:0] Q30_HALF = 62'h2000_0000;
	localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	// register reset values and register indexes
	localparam logic [7:0] RING_COUNT_RESET = 8'd16;
	localparam logic [7:0] SECTOR_COUNT_RESET = 8'd32;
	localparam logic REG_RING = 1'b0;
	localparam logic REG_SECTOR = 1'b1;

	// taylor series horner steps: divisor, reciprocal and its shift
	localparam int HORNER_STEPS = 6;
	localparam int HORNER_DIV [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};
	localparam int HORNER_SHIFT [HORNER_STEPS] = '{38, 37, 37, 36, 35, 33};
	localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
		32'((64'd1 << 38) / 64'd156),
		32'((64'd1 << 37) / 64'd110),
		32'((64'd1 << 37) / 64'd72),
		32'((64'd1 << 36) / 64'd42),
		32'((64'd1 << 35) / 64'd20),
		32'((64'd1 << 33) / 64'd6)
	};

	// sine pipe register stages: angle, square, x2, three per horner step, two final
	localparam int SIN_LAT = 5 + 3 * HORNER_STEPS;

	// angle divider: 33 quotient bits, three per stage
	localparam int DIV_BITS = 33;
	localparam int DIV_STEP = 3;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

	// pipeline stage of the product register and total depth
	localparam int PIPE_PROD = DIV_STAGES + SIN_LAT + 1;
	localparam int PIPE_DEPTH = PIPE_PROD + 1;

	typedef struct packed {
		logic       kind;
		logic [7:0] ring_index;
		logic [7:0] sector_index;
	} item_t;

	typedef struct packed {
		logic               bad;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [15:0]        tri_a0;
		logic [15:0]        tri_a1;
		logic [15:0]        tri_a2;
		logic [15:0]        tri_b0;
		logic [15:0]        tri_b1;
		logic [15:0]        tri_b2;
	} result_t;

	typedef struct packed {
		logic       kind;
		logic       bad;
		logic [7:0] ring_index;
		logic [7:0] sector_index;
	} side_t;

	typedef struct packed {
		logic [9:0]  rem;
		logic [32:0] quo;
	} div_t;

	typedef struct packed {
		logic [30:0] x;
		logic [31:0] x2;
		logic        neg;
	} sin_carry_t;

	// restoring division, DIV_STEP quotient bits
	function automatic div_t div_stage(div_t cur, logic [DIV_STEP-1:0] bits,
		logic [9:0] divisor);
		div_t nxt;
		logic [10:0] trial;
		nxt = cur;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			trial = {nxt.rem, bits[i]};
			if (trial >= {1'b0, divisor}) begin
				nxt.rem = 10'(trial - {1'b0, divisor});
				nxt.quo = {nxt.quo[31:0], 1'b1};
			end else begin
				nxt.rem = trial[9:0];
				nxt.quo = {nxt.quo[31:0], 1'b0};
			end
		end
		return nxt;
	endfunction

	// q60 product rounded to q30
	function automatic logic [30:0] q30_round(logic [61:0] prod);
		return 31'((prod + Q30_HALF) >> 30);
	endfunction

	// q30 magnitude to signed output coordinate, half away from zero
	function automatic logic signed [15:0] to_coord(logic [30:0] mag, logic neg);
		logic [31:0] sum;
		logic [15:0] v;
		sum = 32'(mag) + (32'd1 << (COORD_SHIFT - 1));
		v = 16'(sum >> COORD_SHIFT);
		return neg ? $signed(16'(16'd0 - v)) : $signed(v);
	endfunction

endpackage

`default_nettype wire

/* design/usmg_sin_pipe.sv */
// pipelined sine of a 32-bit turn fraction: q30 magnitude and sign
// depends on usmg_pkg; every register advances only while en is high
`default_nettype none

module usmg_sin_pipe (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] turn,
	output logic [30:0] mag,
	output logic        neg
);

	logic [30:0] t_c;
	logic [61:0] tp_s1;
	logic        neg_s1;
	logic [30:0] x_c;
	logic [30:0] x_s2;
	logic [61:0] xx_s2;
	logic        neg_s2;

	usmg_pkg::sin_carry_t car_a_s [usmg_pkg::HORNER_STEPS];
	usmg_pkg::sin_carry_t car_b_s [usmg_pkg::HORNER_STEPS];
	usmg_pkg::sin_carry_t car_c_s [usmg_pkg::HORNER_STEPS+1];
	logic [30:0] acc_c_s [usmg_pkg::HORNER_STEPS+1];
	logic [62:0] prod_a_s [usmg_pkg::HORNER_STEPS];
	logic [31:0] q_b_s [usmg_pkg::HORNER_STEPS];
	logic [63:0] qm_b_s [usmg_pkg::HORNER_STEPS];

	logic [61:0] fp_s;
	logic        fneg_s;
	logic [31:0] fin_c;
	logic [30:0] mag_s;
	logic        neg_s;

	// fold into first quadrant
	always_comb begin
		if (turn[30]) begin
			t_c = usmg_pkg::Q30_ONE - {1'b0, turn[29:0]};
		end else begin
			t_c = {1'b0, turn[29:0]};
		end
	end

	// angle in radians, q30
	always_ff @(posedge clk) begin
		if (en) begin
			tp_s1  <= 62'(t_c) * 62'(usmg_pkg::PI_HALF_Q30);
			neg_s1 <= turn[31];
		end
	end

	assign x_c = usmg_pkg::q30_round(tp_s1);

	// square of the angle
	always_ff @(posedge clk) begin
		if (en) begin
			x_s2   <= x_c;
			xx_s2  <= 62'(x_c) * 62'(x_c);
			neg_s2 <= neg_s1;
		end
	end

	// start of the horner chain
	always_ff @(posedge clk) begin
		if (en) begin
			car_c_s[0].x   <= x_s2;
			car_c_s[0].x2  <= 32'((xx_s2 + usmg_pkg::Q30_HALF) >> 30);
			car_c_s[0].neg <= neg_s2;
			acc_c_s[0]     <= usmg_pkg::Q30_ONE;
		end
	end

	// horner steps: multiply, reciprocal multiply, correct and subtract
	for (genvar k = 0; k < usmg_pkg::HORNER_STEPS; k++) begin : g_horner
		logic [31:0] est_c;
		logic [39:0] back_c;
		logic [39:0] q40_c;
		logic [31:0] quot_c;

		always_ff @(posedge clk) begin
			if (en) begin
				prod_a_s[k] <= 63'(car_c_s[k].x2) * 63'(acc_c_s[k]);
				car_a_s[k]  <= car_c_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_b_s[k]   <= 32'(prod_a_s[k] >> 30);
				qm_b_s[k]  <= 64'(32'(prod_a_s[k] >> 30)) * 64'(usmg_pkg::HORNER_RECIP[k]);
				car_b_s[k] <= car_a_s[k];
			end
		end

		// estimate is off by at most one
		always_comb begin
			est_c  = 32'(qm_b_s[k] >> usmg_pkg::HORNER_SHIFT[k]);
			back_c = 40'(est_c) * 40'(usmg_pkg::HORNER_DIV[k]);
			q40_c  = 40'(q_b_s[k]);
			if (back_c > q40_c) begin
				quot_c = est_c - 32'd1;
			end else if ((q40_c - back_c) >= 40'(usmg_pkg::HORNER_DIV[k])) begin
				quot_c = est_c + 32'd1;
			end else begin
				quot_c = est_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_c_s[k+1] <= 31'(32'(usmg_pkg::Q30_ONE) - quot_c);
				car_c_s[k+1] <= car_b_s[k];
			end
		end
	end

	// final product with the angle
	always_ff @(posedge clk) begin
		if (en) begin
			fp_s   <= 62'(car_c_s[usmg_pkg::HORNER_STEPS].x) *
				62'(acc_c_s[usmg_pkg::HORNER_STEPS]);
			fneg_s <= car_c_s[usmg_pkg::HORNER_STEPS].neg;
		end
	end

	assign fin_c = 32'(fp_s >> 30);

	// limit to one
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s <= (fin_c > 32'(usmg_pkg::Q30_ONE)) ? usmg_pkg::Q30_ONE : fin_c[30:0];
			neg_s <= fneg_s;
		end
	end

	assign mag = mag_s;
	assign neg = neg_s;

endmodule

`default_nettype wire

/* design/uv_sphere_mesh_generator.sv */
// uv sphere mesh generator top level: config registers, angle dividers,
// sine pipes, product stage and output skid; depends on usmg_pkg,
// usmg_sin_pipe and uv_sphere_mesh_generator_macros.svh
//
// An item (kind, ring_index, sector_index) transfers on item_valid and
// item_ready; a vertex item yields a unit sphere point in signed Q2.14,
// a quad item the six vertex indices of its two triangles, and an item
// out of range a result with bad set and all else zero. Results transfer
// on result_valid and result_ready, one per item, in order.
// The user writes ring_count and sector_count over the APB port only while
// no item is in flight; the block does not enforce it. Reset sets them to
// 16 and 32. An item passes the input stage, the 11 angle divider stages,
// the 23 sine pipe stages, the product stage and the result register.
// One item enters per cycle unless stalled; every stage holds a valid bit.
// When the receiver stalls, one more result parks in a skid register and
// the whole pipeline then holds; item_ready is low while the skid is full.
// Reset clears all valid bits, so no result is pending after reset.
`default_nettype none
`include "uv_sphere_mesh_generator_macros.svh"

module uv_sphere_mesh_generator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  usmg_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output usmg_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [7:0] ring_count_q;
	logic [7:0] sector_count_q;
	logic       adv;

	logic                    counts_bad_c;
	logic                    item_bad_c;
	logic [9:0]              phi_div_c;
	logic [9:0]              th_div_c;
	logic [usmg_pkg::DIV_BITS-1:0] phi_word_c;
	logic [usmg_pkg::DIV_BITS-1:0] th_word_c;

	logic [usmg_pkg::PIPE_DEPTH-1:0] pipe_v_s;
	usmg_pkg::side_t side_s [usmg_pkg::PIPE_PROD];
	usmg_pkg::div_t  div_phi_s [usmg_pkg::DIV_STAGES+1];
	usmg_pkg::div_t  div_th_s [usmg_pkg::DIV_STAGES+1];

	logic [31:0] phi_c;
	logic [31:0] th_c;
	logic [30:0] sp_mag, cp_mag, st_mag, ct_mag;
	logic        sp_neg, cp_neg, st_neg, ct_neg;

	logic [8:0]  stride_c;
	logic [17:0] cur_c;
	logic [61:0] xm_prod_s;
	logic [61:0] zm_prod_s;
	logic [30:0] cp_mag_s;
	logic        x_neg_s, y_neg_s, z_neg_s;
	usmg_pkg::side_t side_prod_s;
	logic [15:0] cur_s;
	logic [15:0] nxt_s;

	usmg_pkg::result_t res_c;
	usmg_pkg::result_t result_q;
	usmg_pkg::result_t skid_q;
	logic result_valid_q;
	logic skid_valid_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q   <= usmg_pkg::RING_COUNT_RESET;
			sector_count_q <= usmg_pkg::SECTOR_COUNT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				usmg_pkg::REG_RING:   ring_count_q   <= pwdata[7:0];
				usmg_pkg::REG_SECTOR: sector_count_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (paddr[2])
			usmg_pkg::REG_RING:   prdata = {24'd0, ring_count_q};
			usmg_pkg::REG_SECTOR: prdata = {24'd0, sector_count_q};
			default:              prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// pipeline moves whenever the skid register is empty
	assign adv = !skid_valid_q;
	assign item_ready = adv;

	// range checks and divider operands
	always_comb begin
		counts_bad_c = (ring_count_q == 8'd0) || (sector_count_q == 8'd0) ||
			(32'(ring_count_q) > 32'(usmg_pkg::MAX_DIVISIONS)) ||
			(32'(sector_count_q) > 32'(usmg_pkg::MAX_DIVISIONS));
		if (item.kind) begin
			item_bad_c = counts_bad_c || (item.ring_index >= ring_count_q) ||
				(item.sector_index >= sector_count_q);
		end else begin
			item_bad_c = counts_bad_c || (item.ring_index > ring_count_q) ||
				(item.sector_index > sector_count_q);
		end
		phi_div_c  = {ring_count_q, 2'b00};
		th_div_c   = {1'b0, sector_count_q, 1'b0};
		phi_word_c = usmg_pkg::DIV_BITS'({ring_count_q, 1'b0});
		th_word_c  = usmg_pkg::DIV_BITS'(sector_count_q);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_v_s <= '0;
		end else if (adv) begin
			pipe_v_s <= {pipe_v_s[usmg_pkg::PIPE_DEPTH-2:0], item_valid};
		end
	end

	// input stage
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0].kind         <= item.kind;
			side_s[0].bad          <= item_bad_c;
			side_s[0].ring_index   <= item.ring_index;
			side_s[0].sector_index <= item.sector_index;
			div_phi_s[0].rem       <= 10'(item.ring_index);
			div_phi_s[0].quo       <= '0;
			div_th_s[0].rem        <= 10'(item.sector_index);
			div_th_s[0].quo        <= '0;
		end
	end

	// item fields travel alongside
	for (genvar i = 1; i < usmg_pkg::PIPE_PROD; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// angle dividers: phi = r*2^33+2R over 4R, theta = s*2^33+S over 2S
	for (genvar k = 0; k < usmg_pkg::DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				div_phi_s[k+1] <= usmg_pkg::div_stage(div_phi_s[k],
					phi_word_c[usmg_pkg::DIV_BITS-1-usmg_pkg::DIV_STEP*k -: usmg_pkg::DIV_STEP],
					phi_div_c);
				div_th_s[k+1] <= usmg_pkg::div_stage(div_th_s[k],
					th_word_c[usmg_pkg::DIV_BITS-1-usmg_pkg::DIV_STEP*k -: usmg_pkg::DIV_STEP],
					th_div_c);
			end
		end
	end

	assign phi_c = div_phi_s[usmg_pkg::DIV_STAGES].quo[31:0];
	assign th_c  = div_th_s[usmg_pkg::DIV_STAGES].quo[31:0];

	// sine and cosine of both angles
	usmg_sin_pipe u_sin_phi (
		.clk  (clk),
		.en   (adv),
		.turn (phi_c),
		.mag  (sp_mag),
		.neg  (sp_neg)
	);

	usmg_sin_pipe u_cos_phi (
		.clk  (clk),
		.en   (adv),
		.turn (phi_c + usmg_pkg::QUARTER_TURN),
		.mag  (cp_mag),
		.neg  (cp_neg)
	);

	usmg_sin_pipe u_sin_th (
		.clk  (clk),
		.en   (adv),
		.turn (th_c),
		.mag  (st_mag),
		.neg  (st_neg)
	);

	usmg_sin_pipe u_cos_th (
		.clk  (clk),
		.en   (adv),
		.turn (th_c + usmg_pkg::QUARTER_TURN),
		.mag  (ct_mag),
		.neg  (ct_neg)
	);

	// quad base index
	always_comb begin
		stride_c = 9'(sector_count_q) + 9'd1;
		cur_c = 18'(side_s[usmg_pkg::PIPE_PROD-1].ring_index) * 18'(stride_c) +
			18'(side_s[usmg_pkg::PIPE_PROD-1].sector_index);
	end

	// product stage
	always_ff @(posedge clk) begin
		if (adv) begin
			xm_prod_s   <= 62'(sp_mag) * 62'(st_mag);
			zm_prod_s   <= 62'(sp_mag) * 62'(ct_mag);
			cp_mag_s    <= cp_mag;
			x_neg_s     <= sp_neg ^ st_neg;
			y_neg_s     <= cp_neg;
			z_neg_s     <= sp_neg ^ ct_neg;
			side_prod_s <= side_s[usmg_pkg::PIPE_PROD-1];
			cur_s       <= cur_c[15:0];
			nxt_s       <= 16'(cur_c + 18'(stride_c));
		end
	end

	// result formatting
	always_comb begin
		res_c = '0;
		res_c.bad = side_prod_s.bad;
		if (!side_prod_s.bad && !side_prod_s.kind) begin
			res_c.pos_x = usmg_pkg::to_coord(usmg_pkg::q30_round(xm_prod_s), x_neg_s);
			res_c.pos_y = usmg_pkg::to_coord(cp_mag_s, y_neg_s);
			res_c.pos_z = usmg_pkg::to_coord(usmg_pkg::q30_round(zm_prod_s), z_neg_s);
		end
		if (!side_prod_s.bad && side_prod_s.kind) begin
			res_c.tri_a0 = cur_s;
			res_c.tri_a1 = nxt_s;
			res_c.tri_a2 = nxt_s + 16'd1;
			res_c.tri_b0 = cur_s;
			res_c.tri_b1 = nxt_s + 16'd1;
			res_c.tri_b2 = cur_s + 16'd1;
		end
	end

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (skid_valid_q) begin
			if (result_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!result_valid_q || result_ready) begin
			result_valid_q <= pipe_v_s[usmg_pkg::PIPE_PROD];
		end else if (pipe_v_s[usmg_pkg::PIPE_PROD]) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (result_ready) begin
				result_q <= skid_q;
			end
		end else if (!result_valid_q || result_ready) begin
			result_q <= res_c;
		end else begin
			skid_q <= res_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`USMG_ASSERT_SAME(a_skid_needs_out, skid_valid_q, result_valid_q,
		"skid holds a result while the output register is empty")
	`USMG_ASSERT_NEXT(a_stall_to_skid,
		result_valid_q && !result_ready && !skid_valid_q && pipe_v_s[usmg_pkg::PIPE_PROD],
		skid_valid_q && result_valid_q, "stalled result was not parked in the skid")
	`USMG_ASSERT_NEXT(a_transfer_enters, item_valid && item_ready, pipe_v_s[0],
		"accepted item did not enter the pipeline")
	`USMG_ASSERT_SAME(a_bad_zeroes, result_valid_q && result_q.bad,
		(result_q.pos_x == 16'sd0) && (result_q.pos_y == 16'sd0) &&
		(result_q.pos_z == 16'sd0) && (result_q.tri_a0 == 16'd0) &&
		(result_q.tri_b2 == 16'd0), "bad result carries nonzero fields")

endmodule

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for uv_sphere_mesh_generator: vertex and quad items,
// predicted results compared per field; depends on usmg_pkg and the dut
`timescale 1ns / 1ps

module tb;

	localparam int TIMEOUT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 48;
	localparam bit KIND_VERTEX = 1'b0;
	localparam bit KIND_QUAD = 1'b1;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	usmg_pkg::item_t item;
	logic result_valid;
	logic result_ready;
	usmg_pkg::result_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	uv_sphere_mesh_generator dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor copy of the count registers
	bit [7:0] rings_now;
	bit [7:0] sectors_now;

	usmg_pkg::item_t pending_items[$];
	usmg_pkg::result_t expected_results[$];
	int errors;
	int cycle_count;
	bit send_idle;
	bit recv_idle;
	int send_gap;
	int recv_gap;
	int recv_hold;

	// sine of a quarter-turn fraction, q30 magnitude
	function automatic bit [63:0] quarter_sine(bit [63:0] t);
		bit [63:0] horner_div [6];
		bit [63:0] x;
		bit [63:0] x2;
		bit [63:0] acc;
		horner_div = '{156, 110, 72, 42, 20, 6};
		x = (t * 64'd1686629713 + 64'd536870912) >> 30;
		x2 = (x * x + 64'd536870912) >> 30;
		acc = 64'd1 << 30;
		for (int i = 0; i < 6; i++)
			acc = (64'd1 << 30) - ((x2 * acc) >> 30) / horner_div[i];
		acc = (x * acc) >> 30;
		return (acc > (64'd1 << 30)) ? (64'd1 << 30) : acc;
	endfunction

	// sine of a 32-bit turn fraction, sign returned apart
	function automatic bit [63:0] turn_sine(bit [31:0] u, output bit neg);
		bit [63:0] t;
		t = {34'd0, u[29:0]};
		neg = u[31];
		if (u[30])
			t = (64'd1 << 30) - t;
		return quarter_sine(t);
	endfunction

	// q30 magnitude to output coordinate, half away from zero
	function automatic logic signed [15:0] to_q14(bit [63:0] mag, bit neg);
		bit [63:0] v;
		v = (((mag << 1) >> (30 - usmg_pkg::COORD_FRAC_BITS)) + 64'd1) >> 1;
		if (neg)
			v = 64'd0 - v;
		return v[15:0];
	endfunction

	function automatic usmg_pkg::result_t predict_mesh(usmg_pkg::item_t it);
		usmg_pkg::result_t res;
		bit [63:0] r, s, rc, sc, sp, cp, st, ct, cur, nxt;
		bit [31:0] phi, th;
		bit n_sp, n_cp, n_st, n_ct, bad;
		res = '0;
		r = it.ring_index;
		s = it.sector_index;
		rc = rings_now;
		sc = sectors_now;
		bad = (rc == 0) || (sc == 0) || (rc > usmg_pkg::MAX_DIVISIONS) ||
			(sc > usmg_pkg::MAX_DIVISIONS);
		if (!bad)
			bad = (it.kind == KIND_VERTEX) ? (r > rc || s > sc) : (r >= rc || s >= sc);
		if (bad) begin
			res.bad = 1'b1;
		end else if (it.kind == KIND_VERTEX) begin
			phi = 32'(((r << 32) + rc) / (2 * rc));
			th = 32'(((s << 33) + sc) / (2 * sc));
			sp = turn_sine(phi, n_sp);
			cp = turn_sine(phi + 32'h4000_0000, n_cp);
			st = turn_sine(th, n_st);
			ct = turn_sine(th + 32'h4000_0000, n_ct);
			res.pos_x = to_q14((sp * st + 64'd536870912) >> 30, n_sp != n_st);
			res.pos_y = to_q14(cp, n_cp);
			res.pos_z = to_q14((sp * ct + 64'd536870912) >> 30, n_sp != n_ct);
		end else begin
			cur = r * (sc + 1) + s;
			nxt = (r + 1) * (sc + 1) + s;
			res.tri_a0 = cur[15:0];
			res.tri_a1 = nxt[15:0];
			res.tri_a2 = 16'(nxt + 1);
			res.tri_b0 = cur[15:0];
			res.tri_b1 = 16'(nxt + 1);
			res.tri_b2 = 16'(cur + 1);
		end
		return res;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			errors++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap <= 0;
		end else if (!(item_valid && !item_ready)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
				send_gap <= send_idle ? $urandom_range(0, 13) : 0;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result receiver with random waits and an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_gap <= 0;
		end else if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			result_ready <= 1'b0;
		end else if (result_valid && result_ready) begin
			int w;
			w = recv_idle ? $urandom_range(0, 13) : 0;
			recv_gap <= w;
			result_ready <= (w == 0);
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			result_ready <= (recv_gap == 1);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// monitor: predict on item transfer, check on result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (item_valid && item_ready)
				expected_results = {expected_results, predict_mesh(item)};
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer");
					errors++;
				end else begin
					usmg_pkg::result_t want;
					want = expected_results.pop_front();
					check_field("bad", want.bad, result.bad);
					check_field("pos_x", want.pos_x, result.pos_x);
					check_field("pos_y", want.pos_y, result.pos_y);
					check_field("pos_z", want.pos_z, result.pos_z);
					check_field("tri_a0", want.tri_a0, result.tri_a0);
					check_field("tri_a1", want.tri_a1, result.tri_a1);
					check_field("tri_a2", want.tri_a2, result.tri_a2);
					check_field("tri_b0", want.tri_b0, result.tri_b0);
					check_field("tri_b1", want.tri_b1, result.tri_b1);
					check_field("tri_b2", want.tri_b2, result.tri_b2);
				end
			end
			if (cycle_count > TIMEOUT_CYCLES) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// apb write: setup then access
	task automatic write_count(bit idx, bit [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= (idx == usmg_pkg::REG_SECTOR) ? 3'd4 : 3'd0;
		pwdata <= {24'($urandom_range(0, 16777215)), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == usmg_pkg::REG_SECTOR)
			sectors_now = value;
		else
			rings_now = value;
	endtask

	task automatic add_item(bit kind, int r, int s);
		usmg_pkg::item_t it;
		it.kind = kind;
		it.ring_index = r[7:0];
		it.sector_index = s[7:0];
		pending_items = {pending_items, it};
	endtask

	// wait until every transfer has drained, then let the pipe settle
	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// random items, mostly near the valid ranges
	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8)
				add_item(1'($urandom_range(0, 1)), $urandom_range(0, rings_now + 1),
					$urandom_range(0, sectors_now + 1));
			else
				add_item(1'($urandom_range(0, 1)), $urandom_range(0, 255),
					$urandom_range(0, 255));
		end
	endtask

	initial begin
		int rings_set [10];
		int sectors_set [10];
		rings_set = '{1, 255, 0, 7, 3, 255, 2, 0, 0, 0};
		sectors_set = '{1, 255, 5, 0, 255, 1, 3, 0, 0, 0};
		for (int i = 7; i < 10; i++) begin
			rings_set[i] = $urandom_range(1, 255);
			sectors_set[i] = $urandom_range(1, 255);
		end
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycle_count = 0;
		recv_hold = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		rings_now = usmg_pkg::RING_COUNT_RESET;
		sectors_now = usmg_pkg::SECTOR_COUNT_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: poles, seam, equator, range edges, both kinds
		add_item(KIND_VERTEX, 0, 0);
		add_item(KIND_VERTEX, 16, 32);
		add_item(KIND_VERTEX, 8, 0);
		add_item(KIND_VERTEX, 8, 8);
		add_item(KIND_VERTEX, 8, 16);
		add_item(KIND_VERTEX, 8, 24);
		add_item(KIND_VERTEX, 4, 5);
		add_item(KIND_VERTEX, 12, 27);
		add_item(KIND_VERTEX, 17, 0);
		add_item(KIND_VERTEX, 0, 33);
		add_item(KIND_VERTEX, 255, 255);
		add_item(KIND_QUAD, 0, 0);
		add_item(KIND_QUAD, 15, 31);
		add_item(KIND_QUAD, 16, 0);
		add_item(KIND_QUAD, 0, 32);
		add_item(KIND_QUAD, 255, 255);
		add_item(KIND_QUAD, 7, 13);
		wait_drained();

		// random at reset counts, first with the receiver held off
		send_idle = 1'b0;
		recv_hold <= 400;
		add_random(120);
		wait_drained();
		send_idle = 1'b1;
		add_random(100);
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			write_count(usmg_pkg::REG_RING, 8'(rings_set[p]));
			write_count(usmg_pkg::REG_SECTOR, 8'(sectors_set[p]));
			if (p == 1) begin
				add_item(KIND_QUAD, 254, 254);
				add_item(KIND_VERTEX, 255, 255);
				add_item(KIND_VERTEX, 128, 64);
			end
			send_idle = (p % 3 != 2);
			recv_idle = (p % 4 != 3);
			add_random(160);
			wait_drained();
		end

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/usmg_pkg.sv
design/usmg_sin_pipe.sv
design/uv_sphere_mesh_generator.sv
tb/tb.sv
